### hdl/tcpt_pkg.sv
// Package for the triangle circumcircle and point test pipeline.
// Holds widths, the carried-along item records and the divider and square root step
// functions. It depends on nothing.
`default_nettype none

package tcpt_pkg;

    localparam int COORD_W = 16;   // input coordinate width
    localparam int DIFF_W  = 17;   // coordinate difference
    localparam int PROD_W  = 36;   // product of two differences, cross products
    localparam int SQ_W    = 35;   // sums of squares and |cross|
    localparam int NUM_W   = 54;   // signed center numerators and offsets
    localparam int MAG_W   = 53;   // magnitude of a numerator or quotient
    localparam int DEN_W   = 37;   // divisor 2*|cross|
    localparam int SPLIT   = 27;   // split point of the offset for partial products
    localparam int PART_W  = 46;   // partial product width
    localparam int SUM_W   = 72;   // dot product (P-A).(O-A)
    localparam int OUT_W   = 32;   // center and radius width
    localparam int ROOT_W  = 32;   // square root result
    localparam int RAD_W   = 64;   // square root operand
    localparam int SREM_W  = 35;   // square root partial remainder

    typedef struct packed {
        logic                        swapped;
        logic                        collinear;
        logic                        in_tri;
        logic signed [COORD_W-1:0]   x0;
        logic signed [COORD_W-1:0]   y0;
        logic signed [DIFF_W-1:0]    rx;
        logic signed [DIFF_W-1:0]    ry;
        logic        [SQ_W-1:0]      lsq;
    } side_t;

    typedef struct packed {
        logic              swapped;
        logic              collinear;
        logic              in_tri;
        logic              in_circ;
        logic              ovf_c;
        logic              rad_sat;
        logic [OUT_W-1:0]  cx;
        logic [OUT_W-1:0]  cy;
    } res_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [MAG_W-1:0] nq;     // numerator bits still to go, quotient bits shifted in
    } div_t;

    typedef struct packed {
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  n;
    } sqrt_t;

    function automatic logic signed [DIFF_W-1:0] dsub(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic signed [PROD_W-1:0] smul(
        input logic signed [DIFF_W-1:0] a,
        input logic signed [DIFF_W-1:0] b
    );
        return PROD_W'(a) * PROD_W'(b);
    endfunction

    // One restoring division step: one quotient bit.
    function automatic div_t div_step(input div_t s, input logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        logic           ge;
        div_t           r;
        t      = {s.rem, s.nq[MAG_W-1]};
        ge     = (t >= {1'b0, den});
        r.rem  = ge ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
        r.nq   = {s.nq[MAG_W-2:0], ge};
        return r;
    endfunction

    // One digit-by-digit square root step: one root bit from two operand bits.
    function automatic sqrt_t sqrt_step(input sqrt_t s);
        logic [SREM_W-1:0] t;
        logic [SREM_W-1:0] trial;
        logic              ge;
        sqrt_t             r;
        t      = {s.rem[SREM_W-3:0], s.n[RAD_W-1 -: 2]};
        trial  = {1'b0, s.root, 2'b01};
        ge     = (t >= trial);
        r.rem  = ge ? (t - trial) : t;
        r.root = {s.root[ROOT_W-2:0], ge};
        r.n    = {s.n[RAD_W-3:0], 2'b00};
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/triangle_circumcircle_point_test.sv
// Top level of the triangle circumcircle and point test pipeline.
// Depends on tcpt_pkg for widths, item records and the divider and root steps.
//
// Usage: an item on the input channel (in_valid/in_ready) carries three
// triangle vertices A, B, C and a query point P as signed Q11.4 values. The
// result item on the output channel (out_valid/out_ready) gives the
// counter-clockwise order flag, the collinear flag, the circumcenter and the
// circumradius (saturated, with an overflow flag), and whether P lies in or on
// the triangle and in or on the circumcircle.
//
// From an accepted item to its result there are six arithmetic
// stages, a 53-stage restoring divider (one quotient bit per stage) for the
// two center offsets, four stages of squaring, saturation and the exact
// in-circle compare, a 32-stage square root (one root bit per stage), and the
// output register. Throughput is one item per cycle while the output is not stalled.
//
// Reset clears every valid bit of the pipeline; data registers are not reset.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated, and the
// pipeline moves again in the cycle out_ready returns.
`default_nettype none

module triangle_circumcircle_point_test (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output      logic                              in_ready,
    input  wire logic signed [tcpt_pkg::COORD_W-1:0] ax,
    input  wire logic signed [tcpt_pkg::COORD_W-1:0] ay,
    input  wire logic signed [tcpt_pkg::COORD_W-1:0] bx,
    input  wire logic signed [tcpt_pkg::COORD_W-1:0] by_coord,
    input  wire logic signed [tcpt_pkg::COORD_W-1:0] cx,
    input  wire logic signed [tcpt_pkg::COORD_W-1:0] cy,
    input  wire logic signed [tcpt_pkg::COORD_W-1:0] px,
    input  wire logic signed [tcpt_pkg::COORD_W-1:0] py,
    output      logic                              out_valid,
    input  wire logic                              out_ready,
    output      logic                              swapped,
    output      logic                              collinear,
    output      logic signed [tcpt_pkg::OUT_W-1:0] center_x,
    output      logic signed [tcpt_pkg::OUT_W-1:0] center_y,
    output      logic        [tcpt_pkg::OUT_W-1:0] radius,
    output      logic                              overflow,
    output      logic                              in_triangle,
    output      logic                              in_circle
);

    localparam int CW  = tcpt_pkg::COORD_W;
    localparam int DW  = tcpt_pkg::DIFF_W;
    localparam int PW  = tcpt_pkg::PROD_W;
    localparam int SW  = tcpt_pkg::SQ_W;
    localparam int NW  = tcpt_pkg::NUM_W;
    localparam int MW  = tcpt_pkg::MAG_W;
    localparam int EW  = tcpt_pkg::DEN_W;
    localparam int SP  = tcpt_pkg::SPLIT;
    localparam int AW  = tcpt_pkg::PART_W;
    localparam int UW  = tcpt_pkg::SUM_W;
    localparam int OW  = tcpt_pkg::OUT_W;
    localparam int RW  = tcpt_pkg::ROOT_W;
    localparam int QW  = tcpt_pkg::RAD_W;

    // Global advance: the pipeline moves unless a result is waiting and stalled.
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- stage 1: raw cross product terms ----------------
    logic v1_reg;
    logic signed [CW-1:0] s1_x0_reg, s1_y0_reg, s1_x1_reg, s1_y1_reg;
    logic signed [CW-1:0] s1_x2_reg, s1_y2_reg, s1_qx_reg, s1_qy_reg;
    logic signed [PW-1:0] s1_p1_reg, s1_p2_reg;

    // ---------------- stage 2: orientation and vertex order ----------------
    logic v2_reg;
    logic signed [CW-1:0] s2_x0_reg, s2_y0_reg, s2_x1_reg, s2_y1_reg;
    logic signed [CW-1:0] s2_x2_reg, s2_y2_reg, s2_qx_reg, s2_qy_reg;
    logic [SW-1:0]        s2_d_reg;
    logic                 s2_swp_reg, s2_col_reg;
    logic signed [PW-1:0] s2_dsg;

    // ---------------- stage 3: edge vectors, squares, cross terms ----------------
    logic v3_reg;
    logic signed [CW-1:0] s3_x0_reg, s3_y0_reg;
    logic signed [DW-1:0] s3_bx_reg, s3_by_reg, s3_ex_reg, s3_ey_reg, s3_rx_reg, s3_ry_reg;
    logic signed [PW-1:0] s3_bxbx_reg, s3_byby_reg, s3_exex_reg, s3_eyey_reg;
    logic signed [PW-1:0] s3_rxrx_reg, s3_ryry_reg;
    logic signed [PW-1:0] s3_m1a_reg, s3_m1b_reg, s3_m2a_reg, s3_m2b_reg;
    logic signed [PW-1:0] s3_m3a_reg, s3_m3b_reg, s3_m4a_reg, s3_m4b_reg;
    logic [SW-1:0]        s3_d_reg;
    logic                 s3_swp_reg, s3_col_reg, s3_box_reg;
    logic signed [DW-1:0] s3_bx, s3_by, s3_ex, s3_ey, s3_rx, s3_ry;

    // ---------------- stage 4: sums and point-in-triangle ----------------
    logic v4_reg;
    tcpt_pkg::side_t      s4_side_reg;
    logic signed [DW-1:0] s4_bx_reg, s4_by_reg, s4_ex_reg, s4_ey_reg;
    logic [SW-1:0]        s4_bb_reg, s4_ee_reg, s4_d_reg;
    logic signed [PW-1:0] c1, c2, c3, c4;
    tcpt_pkg::side_t      s4_side;

    // ---------------- stage 5: numerator products ----------------
    logic v5_reg;
    tcpt_pkg::side_t      s5_side_reg;
    logic signed [NW-1:0] s5_t1_reg, s5_t2_reg, s5_t3_reg, s5_t4_reg;
    logic [SW-1:0]        s5_d_reg;

    // ---------------- divider pipeline (entry is stage 6) ----------------
    logic                 dv_reg   [0:MW];
    tcpt_pkg::div_t       dx_reg   [0:MW];
    tcpt_pkg::div_t       dy_reg   [0:MW];
    logic [EW-1:0]        den_reg  [0:MW];
    logic                 negx_reg [0:MW];
    logic                 negy_reg [0:MW];
    tcpt_pkg::side_t      dside_reg[0:MW];
    logic signed [NW-1:0] numx, numy;

    // ---------------- post-divider stages ----------------
    logic                 p1_v_reg, p2_v_reg, p3_v_reg;
    tcpt_pkg::side_t      p1_side_reg, p2_side_reg, p3_side_reg;
    logic signed [NW-1:0] p1_ux_reg, p1_uy_reg;
    logic [OW-1:0]        p2_cx_reg, p2_cy_reg, p3_cx_reg, p3_cy_reg;
    logic                 p2_ovc_reg, p2_big_reg, p3_ovc_reg, p3_big_reg;
    logic [RW-1:0]        p2_aux_reg, p2_auy_reg;
    logic signed [AW-1:0] p2_pxl_reg, p2_pxh_reg, p2_pyl_reg, p2_pyh_reg;
    logic [QW-1:0]        p3_s1_reg, p3_s2_reg;
    logic signed [UW-1:0] p3_dot_reg;
    logic signed [NW:0]   p2_sx, p2_sy;
    logic [MW-1:0]        p2_ax, p2_ay;
    logic                 p2_ovx, p2_ovy;
    logic [QW:0]          p4_sum;
    tcpt_pkg::res_t       p4_res;

    // ---------------- square root pipeline ----------------
    logic                 rv_reg  [0:RW];
    tcpt_pkg::sqrt_t      rt_reg  [0:RW];
    tcpt_pkg::res_t       rres_reg[0:RW];

    // ---------------- output register ----------------
    tcpt_pkg::res_t       out_res_reg;
    logic [RW-1:0]        out_root_reg;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= MW; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= RW; k++)
            begin
                rv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            dv_reg[0] <= v5_reg;
            for (int k = 0; k < MW; k++)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
            p1_v_reg  <= dv_reg[MW];
            p2_v_reg  <= p1_v_reg;
            p3_v_reg  <= p2_v_reg;
            rv_reg[0] <= p3_v_reg;
            for (int k = 0; k < RW; k++)
            begin
                rv_reg[k+1] <= rv_reg[k];
            end
            out_valid_reg <= rv_reg[RW];
        end
    end

    // Combinational helpers between stages.
    always_comb
    begin
        s2_dsg = s1_p1_reg - s1_p2_reg;

        s3_bx = tcpt_pkg::dsub(s2_x1_reg, s2_x0_reg);
        s3_by = tcpt_pkg::dsub(s2_y1_reg, s2_y0_reg);
        s3_ex = tcpt_pkg::dsub(s2_x2_reg, s2_x0_reg);
        s3_ey = tcpt_pkg::dsub(s2_y2_reg, s2_y0_reg);
        s3_rx = tcpt_pkg::dsub(s2_qx_reg, s2_x0_reg);
        s3_ry = tcpt_pkg::dsub(s2_qy_reg, s2_y0_reg);

        c1 = s3_m1a_reg - s3_m1b_reg;
        c2 = s3_m2a_reg - s3_m2b_reg;
        c3 = s3_m3a_reg - s3_m3b_reg;
        c4 = s3_m4a_reg - s3_m4b_reg;
        s4_side.swapped   = s3_swp_reg;
        s4_side.collinear = s3_col_reg;
        // Collinear vertices: P must sit on their line and inside their box.
        s4_side.in_tri    = s3_col_reg
                          ? (c1 == '0 && c2 == '0 && s3_box_reg)
                          : (!c1[PW-1] && !c3[PW-1] && !c4[PW-1]);
        s4_side.x0        = s3_x0_reg;
        s4_side.y0        = s3_y0_reg;
        s4_side.rx        = s3_rx_reg;
        s4_side.ry        = s3_ry_reg;
        s4_side.lsq       = SW'(s3_rxrx_reg + s3_ryry_reg);

        numx = s5_t1_reg - s5_t2_reg;
        numy = s5_t3_reg - s5_t4_reg;

        p2_sx  = (NW+1)'(p1_side_reg.x0) + (NW+1)'(p1_ux_reg);
        p2_sy  = (NW+1)'(p1_side_reg.y0) + (NW+1)'(p1_uy_reg);
        p2_ovx = (p2_sx[NW:OW-1] != {(NW-OW+2){p2_sx[OW-1]}});
        p2_ovy = (p2_sy[NW:OW-1] != {(NW-OW+2){p2_sy[OW-1]}});
        p2_ax  = p1_ux_reg[NW-1] ? MW'(-p1_ux_reg) : MW'(p1_ux_reg);
        p2_ay  = p1_uy_reg[NW-1] ? MW'(-p1_uy_reg) : MW'(p1_uy_reg);

        p4_sum            = {1'b0, p3_s1_reg} + {1'b0, p3_s2_reg};
        p4_res.swapped    = p3_side_reg.swapped;
        p4_res.collinear  = p3_side_reg.collinear;
        p4_res.in_tri     = p3_side_reg.in_tri;
        // |P-O|^2 <= |A-O|^2 is |P-A|^2 <= 2 (P-A).(O-A).
        p4_res.in_circ    = !p3_dot_reg[UW-1]
                          && ({p3_dot_reg[UW-2:0], 1'b0} >= UW'(p3_side_reg.lsq));
        p4_res.ovf_c      = p3_ovc_reg;
        p4_res.rad_sat    = p3_big_reg || p4_sum[QW];
        p4_res.cx         = p3_cx_reg;
        p4_res.cy         = p3_cy_reg;
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1
            s1_x0_reg <= ax;
            s1_y0_reg <= ay;
            s1_x1_reg <= bx;
            s1_y1_reg <= by_coord;
            s1_x2_reg <= cx;
            s1_y2_reg <= cy;
            s1_qx_reg <= px;
            s1_qy_reg <= py;
            s1_p1_reg <= tcpt_pkg::smul(tcpt_pkg::dsub(bx, ax), tcpt_pkg::dsub(cy, ay));
            s1_p2_reg <= tcpt_pkg::smul(tcpt_pkg::dsub(by_coord, ay), tcpt_pkg::dsub(cx, ax));

            // Stage 2: exchange B and C unless the cross product is positive.
            s2_x0_reg  <= s1_x0_reg;
            s2_y0_reg  <= s1_y0_reg;
            s2_qx_reg  <= s1_qx_reg;
            s2_qy_reg  <= s1_qy_reg;
            s2_col_reg <= (s2_dsg == '0);
            if (s2_dsg[PW-1] || s2_dsg == '0)
            begin
                s2_swp_reg <= 1'b1;
                s2_x1_reg  <= s1_x2_reg;
                s2_y1_reg  <= s1_y2_reg;
                s2_x2_reg  <= s1_x1_reg;
                s2_y2_reg  <= s1_y1_reg;
                s2_d_reg   <= SW'(-s2_dsg);
            end
            else
            begin
                s2_swp_reg <= 1'b0;
                s2_x1_reg  <= s1_x1_reg;
                s2_y1_reg  <= s1_y1_reg;
                s2_x2_reg  <= s1_x2_reg;
                s2_y2_reg  <= s1_y2_reg;
                s2_d_reg   <= SW'(s2_dsg);
            end

            // Stage 3
            s3_x0_reg   <= s2_x0_reg;
            s3_y0_reg   <= s2_y0_reg;
            s3_bx_reg   <= s3_bx;
            s3_by_reg   <= s3_by;
            s3_ex_reg   <= s3_ex;
            s3_ey_reg   <= s3_ey;
            s3_rx_reg   <= s3_rx;
            s3_ry_reg   <= s3_ry;
            s3_bxbx_reg <= tcpt_pkg::smul(s3_bx, s3_bx);
            s3_byby_reg <= tcpt_pkg::smul(s3_by, s3_by);
            s3_exex_reg <= tcpt_pkg::smul(s3_ex, s3_ex);
            s3_eyey_reg <= tcpt_pkg::smul(s3_ey, s3_ey);
            s3_rxrx_reg <= tcpt_pkg::smul(s3_rx, s3_rx);
            s3_ryry_reg <= tcpt_pkg::smul(s3_ry, s3_ry);
            s3_m1a_reg  <= tcpt_pkg::smul(s3_bx, s3_ry);
            s3_m1b_reg  <= tcpt_pkg::smul(s3_by, s3_rx);
            s3_m2a_reg  <= tcpt_pkg::smul(s3_ex, s3_ry);
            s3_m2b_reg  <= tcpt_pkg::smul(s3_ey, s3_rx);
            s3_m3a_reg  <= tcpt_pkg::smul(tcpt_pkg::dsub(s2_x2_reg, s2_x1_reg),
                                          tcpt_pkg::dsub(s2_qy_reg, s2_y1_reg));
            s3_m3b_reg  <= tcpt_pkg::smul(tcpt_pkg::dsub(s2_y2_reg, s2_y1_reg),
                                          tcpt_pkg::dsub(s2_qx_reg, s2_x1_reg));
            s3_m4a_reg  <= tcpt_pkg::smul(tcpt_pkg::dsub(s2_x0_reg, s2_x2_reg),
                                          tcpt_pkg::dsub(s2_qy_reg, s2_y2_reg));
            s3_m4b_reg  <= tcpt_pkg::smul(tcpt_pkg::dsub(s2_y0_reg, s2_y2_reg),
                                          tcpt_pkg::dsub(s2_qx_reg, s2_x2_reg));
            s3_d_reg    <= s2_d_reg;
            s3_swp_reg  <= s2_swp_reg;
            s3_col_reg  <= s2_col_reg;
            s3_box_reg  <= (s2_qx_reg >= s2_x0_reg || s2_qx_reg >= s2_x1_reg
                            || s2_qx_reg >= s2_x2_reg)
                        && (s2_qx_reg <= s2_x0_reg || s2_qx_reg <= s2_x1_reg
                            || s2_qx_reg <= s2_x2_reg)
                        && (s2_qy_reg >= s2_y0_reg || s2_qy_reg >= s2_y1_reg
                            || s2_qy_reg >= s2_y2_reg)
                        && (s2_qy_reg <= s2_y0_reg || s2_qy_reg <= s2_y1_reg
                            || s2_qy_reg <= s2_y2_reg);

            // Stage 4
            s4_side_reg <= s4_side;
            s4_bx_reg   <= s3_bx_reg;
            s4_by_reg   <= s3_by_reg;
            s4_ex_reg   <= s3_ex_reg;
            s4_ey_reg   <= s3_ey_reg;
            s4_bb_reg   <= SW'(s3_bxbx_reg + s3_byby_reg);
            s4_ee_reg   <= SW'(s3_exex_reg + s3_eyey_reg);
            s4_d_reg    <= s3_d_reg;

            // Stage 5
            s5_side_reg <= s4_side_reg;
            s5_d_reg    <= s4_d_reg;
            s5_t1_reg   <= NW'(s4_ey_reg) * NW'($signed({1'b0, s4_bb_reg}));
            s5_t2_reg   <= NW'(s4_by_reg) * NW'($signed({1'b0, s4_ee_reg}));
            s5_t3_reg   <= NW'(s4_bx_reg) * NW'($signed({1'b0, s4_ee_reg}));
            s5_t4_reg   <= NW'(s4_ex_reg) * NW'($signed({1'b0, s4_bb_reg}));

            // Divider entry; a collinear item divides by one and is discarded later.
            dside_reg[0] <= s5_side_reg;
            negx_reg[0]  <= numx[NW-1];
            negy_reg[0]  <= numy[NW-1];
            dx_reg[0].rem <= '0;
            dy_reg[0].rem <= '0;
            dx_reg[0].nq  <= numx[NW-1] ? MW'(-numx) : MW'(numx);
            dy_reg[0].nq  <= numy[NW-1] ? MW'(-numy) : MW'(numy);
            den_reg[0]    <= s5_side_reg.collinear ? EW'(1) : EW'({s5_d_reg, 1'b0});
            for (int k = 0; k < MW; k++)
            begin
                dx_reg[k+1]    <= tcpt_pkg::div_step(dx_reg[k], den_reg[k]);
                dy_reg[k+1]    <= tcpt_pkg::div_step(dy_reg[k], den_reg[k]);
                den_reg[k+1]   <= den_reg[k];
                negx_reg[k+1]  <= negx_reg[k];
                negy_reg[k+1]  <= negy_reg[k];
                dside_reg[k+1] <= dside_reg[k];
            end

            // Post 1: quotient rounded toward zero.
            p1_side_reg <= dside_reg[MW];
            p1_ux_reg   <= negx_reg[MW] ? -$signed({1'b0, dx_reg[MW].nq})
                                        : $signed({1'b0, dx_reg[MW].nq});
            p1_uy_reg   <= negy_reg[MW] ? -$signed({1'b0, dy_reg[MW].nq})
                                        : $signed({1'b0, dy_reg[MW].nq});

            // Post 2: saturate the center, split offsets for the dot product.
            p2_side_reg <= p1_side_reg;
            p2_ovc_reg  <= p2_ovx || p2_ovy;
            p2_cx_reg   <= p2_ovx ? (p2_sx[NW] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}})
                                  : p2_sx[OW-1:0];
            p2_cy_reg   <= p2_ovy ? (p2_sy[NW] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}})
                                  : p2_sy[OW-1:0];
            p2_big_reg  <= (p2_ax[MW-1:RW] != '0) || (p2_ay[MW-1:RW] != '0);
            p2_aux_reg  <= p2_ax[RW-1:0];
            p2_auy_reg  <= p2_ay[RW-1:0];
            p2_pxl_reg  <= AW'(p1_side_reg.rx) * AW'($signed({1'b0, p1_ux_reg[SP-1:0]}));
            p2_pxh_reg  <= AW'(p1_side_reg.rx) * AW'($signed(p1_ux_reg[NW-1:SP]));
            p2_pyl_reg  <= AW'(p1_side_reg.ry) * AW'($signed({1'b0, p1_uy_reg[SP-1:0]}));
            p2_pyh_reg  <= AW'(p1_side_reg.ry) * AW'($signed(p1_uy_reg[NW-1:SP]));

            // Post 3: squares of the offset and the dot product.
            p3_side_reg <= p2_side_reg;
            p3_ovc_reg  <= p2_ovc_reg;
            p3_big_reg  <= p2_big_reg;
            p3_cx_reg   <= p2_cx_reg;
            p3_cy_reg   <= p2_cy_reg;
            p3_s1_reg   <= QW'(p2_aux_reg) * QW'(p2_aux_reg);
            p3_s2_reg   <= QW'(p2_auy_reg) * QW'(p2_auy_reg);
            p3_dot_reg  <= (UW'(p2_pxh_reg + p2_pyh_reg) <<< SP)
                         + UW'(p2_pxl_reg) + UW'(p2_pyl_reg);

            // Post 4 feeds the square root.
            rres_reg[0]    <= p4_res;
            rt_reg[0].rem  <= '0;
            rt_reg[0].root <= '0;
            rt_reg[0].n    <= p4_sum[QW-1:0];
            for (int k = 0; k < RW; k++)
            begin
                rt_reg[k+1]   <= tcpt_pkg::sqrt_step(rt_reg[k]);
                rres_reg[k+1] <= rres_reg[k];
            end

            // Output register.
            out_res_reg  <= rres_reg[RW];
            out_root_reg <= rt_reg[RW].root;
        end
    end

    // Collinear vertices force the circle results to zero.
    assign out_valid   = out_valid_reg;
    assign swapped     = out_res_reg.swapped;
    assign collinear   = out_res_reg.collinear;
    assign in_triangle = out_res_reg.in_tri;
    assign in_circle   = !out_res_reg.collinear && out_res_reg.in_circ;
    assign center_x    = out_res_reg.collinear ? '0 : $signed(out_res_reg.cx);
    assign center_y    = out_res_reg.collinear ? '0 : $signed(out_res_reg.cy);
    assign radius      = out_res_reg.collinear ? '0
                       : (out_res_reg.rad_sat ? '1 : out_root_reg);
    assign overflow    = !out_res_reg.collinear
                       && (out_res_reg.ovf_c || out_res_reg.rad_sat);

    // A degenerate triangle is never counter-clockwise.
    a_col_swap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && collinear |-> swapped)
        else $error("collinear result without swap");

    a_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && collinear |-> radius == '0 && !overflow && !in_circle)
        else $error("collinear result with circle data");

    // A radius below full scale with overflow means the center saturated.
    a_ovf_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow && radius != '1 |->
            center_x == {1'b0, {(OW-1){1'b1}}} || center_x == {1'b1, {(OW-1){1'b0}}}
            || center_y == {1'b0, {(OW-1){1'b1}}} || center_y == {1'b1, {(OW-1){1'b0}}})
        else $error("overflow without saturated field");

endmodule

`default_nettype wire

### bench/triangle_circumcircle_point_test_checker.sv
// Checker for the triangle circumcircle and point test block.
// It watches both channels, predicts each result and compares it as a whole record.
// It uses widths from tcpt_pkg.
module triangle_circumcircle_point_test_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [tcpt_pkg::COORD_W-1:0] ax,
    input  logic signed [tcpt_pkg::COORD_W-1:0] ay,
    input  logic signed [tcpt_pkg::COORD_W-1:0] bx,
    input  logic signed [tcpt_pkg::COORD_W-1:0] by_coord,
    input  logic signed [tcpt_pkg::COORD_W-1:0] cx,
    input  logic signed [tcpt_pkg::COORD_W-1:0] cy,
    input  logic signed [tcpt_pkg::COORD_W-1:0] px,
    input  logic signed [tcpt_pkg::COORD_W-1:0] py,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                swapped,
    input  logic                                collinear,
    input  logic signed [tcpt_pkg::OUT_W-1:0]   center_x,
    input  logic signed [tcpt_pkg::OUT_W-1:0]   center_y,
    input  logic        [tcpt_pkg::OUT_W-1:0]   radius,
    input  logic                                overflow,
    input  logic                                in_triangle,
    input  logic                                in_circle,
    output int                                  mismatches,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        swp;
        logic        col;
        logic [31:0] ctr_x;
        logic [31:0] ctr_y;
        logic [31:0] rad;
        logic        ovf;
        logic        inside_tri;
        logic        inside_circ;
    } circ_result_t;

    circ_result_t pending_results[$];

    function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
        return ux * vy - uy * vx;
    endfunction

    function automatic longint clamp32(longint v, inout logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Floor of the square root, one result bit per pair of operand bits.
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic circ_result_t circumcircle(
        longint x0, longint y0, longint x1, longint y1,
        longint x2, longint y2, longint qx, longint qy
    );
        circ_result_t r;
        longint d, t, dbx, dby, dex, dey, bb, ee, den, ux, uy, rx, ry;
        longint unsigned aux, auy, s1, s2, sum;
        logic signed [127:0] dot, lsq;
        r = '0;
        d = cross2(x1 - x0, y1 - y0, x2 - x0, y2 - y0);
        r.swp = !(d > 0);
        if (r.swp) begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
            d = -d;
        end
        r.col = (d == 0);
        if (r.col) begin
            // Degenerate triangle: P must sit on the common line inside the bounding box.
            r.inside_tri = cross2(x1 - x0, y1 - y0, qx - x0, qy - y0) == 0 &&
                           cross2(x2 - x0, y2 - y0, qx - x0, qy - y0) == 0 &&
                           (qx >= x0 || qx >= x1 || qx >= x2) &&
                           (qx <= x0 || qx <= x1 || qx <= x2) &&
                           (qy >= y0 || qy >= y1 || qy >= y2) &&
                           (qy <= y0 || qy <= y1 || qy <= y2);
            return r;
        end
        dbx = x1 - x0; dby = y1 - y0; dex = x2 - x0; dey = y2 - y0;
        bb = dbx * dbx + dby * dby;
        ee = dex * dex + dey * dey;
        den = 2 * d;
        ux = (dey * bb - dby * ee) / den;   // truncates toward zero
        uy = (dbx * ee - dex * bb) / den;
        r.ctr_x = 32'(clamp32(x0 + ux, r.ovf));
        r.ctr_y = 32'(clamp32(y0 + uy, r.ovf));
        aux = ux < 0 ? -ux : ux;
        auy = uy < 0 ? -uy : uy;
        if (aux >= 64'd1 << 32 || auy >= 64'd1 << 32) begin
            r.rad = '1;
            r.ovf = 1'b1;
        end else begin
            s1 = aux * aux;
            s2 = auy * auy;
            sum = s1 + s2;
            if (sum < s1) begin
                r.rad = '1;
                r.ovf = 1'b1;
            end else begin
                r.rad = 32'(floor_sqrt(sum));
            end
        end
        r.inside_tri = cross2(x1 - x0, y1 - y0, qx - x0, qy - y0) >= 0 &&
                       cross2(x2 - x1, y2 - y1, qx - x1, qy - y1) >= 0 &&
                       cross2(x0 - x2, y0 - y2, qx - x2, qy - y2) >= 0;
        // |P-O|^2 <= |A-O|^2 is the same as |P-A|^2 <= 2 (P-A).(O-A).
        rx = qx - x0;
        ry = qy - y0;
        dot = 128'(rx) * 128'(ux) + 128'(ry) * 128'(uy);
        lsq = 128'(rx * rx + ry * ry);
        r.inside_circ = (2 * dot) >= lsq;
        return r;
    endfunction

    circ_result_t got, want;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pending_results.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            if (in_valid && in_ready)
                pending_results.insert(pending_results.size(),
                    circumcircle(ax, ay, bx, by_coord, cx, cy, px, py));
            if (out_valid && out_ready) begin
                got = {swapped, collinear, center_x, center_y, radius, overflow,
                       in_triangle, in_circle};
                if (pending_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("ERROR: result with no item outstanding: %p", got);
                    mismatches <= mismatches + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("ERROR: result mismatch\n  expected %p\n  actual   %p",
                                     want, got);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            outstanding <= pending_results.size();
        end
    end
endmodule

### bench/tb_triangle_circumcircle_point_test.sv
// Top of the testbench for the triangle circumcircle and point test block.
// It drives items and the receiver's ready, and gives the verdict from the checker's count.
// It depends on tcpt_pkg, the block and triangle_circumcircle_point_test_checker.
module tb_triangle_circumcircle_point_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W    = tcpt_pkg::COORD_W;
    localparam int CYCLE_CAP  = 400000;
    localparam int TAIL_WAIT  = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [COORD_W-1:0] ax = '0, ay = '0, bx = '0, by_coord = '0;
    logic signed [COORD_W-1:0] cx = '0, cy = '0, px = '0, py = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic swapped, collinear, overflow, in_triangle, in_circle;
    logic signed [31:0] center_x, center_y;
    logic [31:0] radius;
    int mismatches, outstanding;

    // Percentages that set how often the sender pauses and the receiver stalls.
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    logic took_item = 1'b0;

    always #2 clk = ~clk;

    triangle_circumcircle_point_test dut (.*);

    triangle_circumcircle_point_test_checker checker_i (.*);

    // Remember whether the last rising edge accepted an item, from pre-edge values.
    always @(posedge clk)
        took_item <= in_valid && in_ready;

    always @(negedge clk)
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offers one item, with random sender pauses first, and returns once it is accepted.
    task automatic send_item(int a_x, int a_y, int b_x, int b_y,
                             int c_x, int c_y, int p_x, int p_y);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        ax <= COORD_W'(a_x); ay <= COORD_W'(a_y);
        bx <= COORD_W'(b_x); by_coord <= COORD_W'(b_y);
        cx <= COORD_W'(c_x); cy <= COORD_W'(c_y);
        px <= COORD_W'(p_x); py <= COORD_W'(p_y);
        in_valid <= 1'b1;
        do
            @(negedge clk);
        while (!took_item);
    endtask

    function automatic int rnd16();
        return int'($signed(16'($urandom)));
    endfunction

    // One random item. Half are local triangles with the point nearby, so that
    // both containment tests go either way; the rest are fully random or cover degenerate shapes.
    task automatic send_random_item();
        int kind, bxc, byc, span, dx, dy, k1, k2, k3;
        int v[8];
        kind = $urandom_range(9);
        span = ($urandom_range(3) == 0) ? 30000 : 200;
        bxc = rnd16();
        byc = rnd16();
        foreach (v[i])
            v[i] = (i % 2 == 0 ? bxc : byc) + $urandom_range(2 * span) - span;
        case (kind)
            5: foreach (v[i]) v[i] = rnd16();
            6, 7: begin
                // Collinear vertices, or nearly so when a one-unit nudge is added.
                dx = $urandom_range(40) - 20;
                dy = $urandom_range(40) - 20;
                k1 = $urandom_range(600) - 300;
                k2 = $urandom_range(600) - 300;
                k3 = $urandom_range(600) - 300;
                v[2] = v[0] + k1 * dx; v[3] = v[1] + k1 * dy;
                v[4] = v[0] + k2 * dx; v[5] = v[1] + k2 * dy;
                if ($urandom_range(1) == 1) begin
                    v[6] = v[0] + k3 * dx; v[7] = v[1] + k3 * dy;
                end
                if (kind == 7)
                    v[5] = v[5] + 1;
            end
            8: begin
                v[2] = v[0]; v[3] = v[1];
            end
            9: begin
                k1 = 2 * $urandom_range(2);
                v[6] = v[k1]; v[7] = v[k1 + 1];
            end
            default: ;
        endcase
        send_item(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endtask

    initial begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed items: extreme coordinates, both vertex orders, vertical and horizontal
        // edges, collinear and coincident vertices, and a point on a vertex or an edge.
        send_item(0, 0, 0, 0, 0, 0, 0, 0);
        send_item(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0);
        send_item(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767);
        send_item(32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768);
        send_item(0, 0, 160, 0, 0, 160, 40, 40);
        send_item(0, 0, 0, 160, 160, 0, 40, 40);
        send_item(0, 0, 0, 100, 50, 50, 0, 50);
        send_item(0, 0, 100, 0, 50, 30, 100, 0);
        send_item(10, 10, 10, 10, 10, 10, 10, 10);
        send_item(0, 0, 100, 100, 200, 200, 150, 150);
        send_item(0, 0, 100, 100, 200, 200, 250, 250);
        send_item(0, 0, 100, 100, 200, 200, 50, 60);
        send_item(-32768, 0, 32767, 1, 0, 0, 0, 0);
        send_item(-32768, -32768, 32767, 32767, 32766, 32767, 32767, -32768);
        send_item(-32768, -32767, 32767, 32767, -32767, -32768, 0, 0);
        send_item(5, 5, 5, 5, 100, 7, 50, 6);
        send_item(0, 0, 300, 0, 150, 400, 150, -100);
        send_item(0, 0, 300, 0, 150, 400, 150, 130);
        send_item(0, 0, 300, 0, 150, 10, 150, 2000);
        send_item(-1, -1, 1, -1, 0, 1, -32768, 32767);

        // Random items in four pressure phases.
        for (int phase = 0; phase < 4; phase++) begin
            send_gap_pct   = (phase == 1 || phase == 3) ? (phase == 1 ? 62 : 33) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 62 : 33) : 0;
            repeat (145) send_random_item();
        end
        in_valid <= 1'b0;

        while (outstanding != 0 || took_item)
            @(negedge clk);
        repeat (TAIL_WAIT) @(negedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
